// File: rtl/core/dps_pkg.sv
// dps_pkg: shared widths, result kind codes and parameter defaults for the
// deadline profit scheduler. No dependencies.
`timescale 1ns / 1ps

package dps_pkg;

   // request / response field widths
   localparam int DUR_W  = 6;
   localparam int PROF_W = 8;
   localparam int DL_W   = 6;
   localparam int KIND_W = 2;
   localparam int VAL_W  = 12;

   // best-profit row entry
   localparam int          ROW_W      = 12;
   localparam logic [ROW_W-1:0] PROFIT_MAX = 12'hFFF;

   // parameter defaults
   localparam int MAX_TIME_DEF = 63;
   localparam int MAX_JOBS_DEF = 16;

   // response kinds
   localparam logic [KIND_W-1:0] KIND_PROFIT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_JOB    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ORDER  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_COUNT  = 2'd3;
   localparam logic [KIND_W-1:0] KIND_NONE   = 2'd0;

endpackage

// File: rtl/core/dps_row_unit.sv
// dps_row_unit: best-profit row memory and its read-modify-write update,
// one finishing time per cycle. Depends on dps_pkg.
`timescale 1ns / 1ps

module dps_row_unit import dps_pkg::*; #(
   parameter int MAX_TIME = MAX_TIME_DEF,
   localparam int TW = (MAX_TIME > 1) ? $clog2(MAX_TIME + 1) : 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              sweep_en,
   input  logic [TW-1:0]     sweep_j,
   input  logic [TW-1:0]     sweep_dp,
   input  logic [DUR_W-1:0]  job_t,
   input  logic [PROF_W-1:0] job_p,
   output logic              ch_valid,
   output logic [TW-1:0]     ch_j,
   output logic              ch_pick,
   output logic [ROW_W-1:0]  row_skip
);

   localparam int XW = (TW > DUR_W) ? TW : DUR_W;

   logic [ROW_W-1:0] row_mem [0:MAX_TIME];

   logic [TW-1:0]     addr_skip;
   logic [TW-1:0]     addr_take;
   logic [XW-1:0]     jx;
   logic [XW-1:0]     tx;
   logic [XW-1:0]     diff;
   logic              take_ok;

   logic [ROW_W-1:0]  skip_raw_ff;
   logic [ROW_W-1:0]  take_raw_ff;
   logic              skip_zero_ff;
   logic              take_zero_ff;
   logic              take_ok_ff;
   logic [TW-1:0]     j1_ff;
   logic [PROF_W-1:0] p1_ff;
   logic              v1_ff;

   logic [ROW_W-1:0]  take_val;
   logic [ROW_W:0]    sum;
   logic [ROW_W-1:0]  sum_sat;
   logic [ROW_W-1:0]  best;

   // read addresses: skip at min(j, dp), take at min(j - t, dp)
   always_comb begin
      jx        = XW'(sweep_j);
      tx        = XW'(job_t);
      take_ok   = (jx >= tx);
      diff      = jx - tx;
      addr_skip = (sweep_j < sweep_dp) ? sweep_j : sweep_dp;
      if (!take_ok) begin
         addr_take = '0;
      end else if (diff < XW'(sweep_dp)) begin
         addr_take = diff[TW-1:0];
      end else begin
         addr_take = sweep_dp;
      end
   end

   always_ff @(posedge clock) begin
      skip_raw_ff  <= row_mem[addr_skip];
      take_raw_ff  <= row_mem[addr_take];
      skip_zero_ff <= (addr_skip == '0);
      take_zero_ff <= (addr_take == '0);
      take_ok_ff   <= take_ok;
      j1_ff        <= sweep_j;
      p1_ff        <= job_p;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= sweep_en;
      end
   end

   // time zero always reads as zero profit
   always_comb begin
      row_skip = skip_zero_ff ? '0 : skip_raw_ff;
      take_val = take_zero_ff ? '0 : take_raw_ff;
      sum      = {1'b0, take_val} + (ROW_W + 1)'(p1_ff);
      sum_sat  = (sum > (ROW_W + 1)'(PROFIT_MAX)) ? PROFIT_MAX : sum[ROW_W-1:0];
      ch_pick  = take_ok_ff && (sum_sat > row_skip);
      best     = ch_pick ? sum_sat : row_skip;
      ch_valid = v1_ff;
      ch_j     = j1_ff;
   end

   always_ff @(posedge clock) begin
      if (v1_ff) begin
         row_mem[j1_ff] <= best;
      end
   end

`ifndef SYNTHESIS
   // descending sweep: reads never touch the entry still being written
   a_no_hazard: assert property (@(posedge clock) disable iff (reset)
      (v1_ff && sweep_en) |-> (addr_skip < j1_ff && (!take_ok || addr_take < j1_ff)))
      else $error("row read overlaps pending write");
   a_wr_range: assert property (@(posedge clock) disable iff (reset)
      v1_ff |-> (j1_ff != '0 && j1_ff <= TW'(MAX_TIME)))
      else $error("row write index out of range");
   a_pick_fit: assert property (@(posedge clock) disable iff (reset)
      (v1_ff && ch_pick) |-> $past(jx >= tx))
      else $error("job taken before its duration fits");
`endif

endmodule

// File: rtl/core/deadline_profit_schedule_dp.sv
// deadline_profit_schedule_dp: top level of the deadline profit scheduler.
// Holds control, job and choice memories, traceback and response register.
// Depends on dps_pkg and dps_row_unit.
`timescale 1ns / 1ps
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-----------------------------------------
//  req     | in        | req_valid/req_stall  | job_duration, job_profit, job_deadline,
//          |           |                      | last_job
//  rsp     | out       | rsp_valid/rsp_stall  | result_kind, result_value, result_last
//
//  Steps: a job request is accepted, sweeps times d..1 one per cycle, then drains.
//    last_job adds a read of the total and a traceback (a read and a use per held job,
//    and a final read), then the total response and a scan of job slots to the last chosen one.
//  Reset: synchronous, active high; clears counts, error and control state.
//    Row memory needs no clearing pass: only entries written this run are read.
//  Stalls: responses sit in an output register; rsp_stall only holds emission.
//

module deadline_profit_schedule_dp import dps_pkg::*; #(
   parameter int MAX_TIME = MAX_TIME_DEF,
   parameter int MAX_JOBS = MAX_JOBS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [DUR_W-1:0]  req_job_duration,
   input  logic [PROF_W-1:0] req_job_profit,
   input  logic [DL_W-1:0]   req_job_deadline,
   input  logic              req_last_job,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [KIND_W-1:0] rsp_result_kind,
   output logic [VAL_W-1:0]  rsp_result_value,
   output logic              rsp_result_last
);

   localparam int TW   = (MAX_TIME > 1) ? $clog2(MAX_TIME + 1) : 1;
   localparam int JW   = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
   localparam int CNTW = $clog2(MAX_JOBS + 1);
   localparam int XW   = (TW > DL_W) ? TW : DL_W;
   localparam int CH_DEPTH = MAX_JOBS << TW;

   // control states
   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_SWEEP    = 4'd1;
   localparam logic [3:0] S_DRAIN    = 4'd2;
   localparam logic [3:0] S_TOT_RD   = 4'd3;
   localparam logic [3:0] S_TOT_WAIT = 4'd4;
   localparam logic [3:0] S_TB_RD    = 4'd5;
   localparam logic [3:0] S_TB_USE   = 4'd6;
   localparam logic [3:0] S_EMIT_TOT = 4'd7;
   localparam logic [3:0] S_EMIT_JOB = 4'd8;
   localparam logic [3:0] S_EMIT_ERR = 4'd9;

   // job memory entry: duration and the previous job's deadline
   logic [DUR_W+TW-1:0] job_mem [0:MAX_JOBS-1];
   logic                ch_mem  [0:CH_DEPTH-1];

   logic [3:0]          state_ff, state_in;
   logic [CNTW-1:0]     count_ff, count_in;
   logic [KIND_W-1:0]   err_ff, err_in;
   logic [TW-1:0]       prevd_ff, prevd_in;
   logic                last_ff, last_in;
   logic [TW-1:0]       j_ff, j_in;
   logic [TW-1:0]       dp_ff, dp_in;
   logic [JW-1:0]       idx_ff, idx_in;
   logic [DUR_W-1:0]    t_ff, t_in;
   logic [PROF_W-1:0]   p_ff, p_in;
   logic [CNTW-1:0]     i_ff, i_in;
   logic [TW-1:0]       jt_ff, jt_in;
   logic [MAX_JOBS-1:0] mask_ff, mask_in;
   logic [JW-1:0]       k_ff, k_in;
   logic [ROW_W-1:0]    total_ff, total_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]   kind_ff, kind_in;
   logic [VAL_W-1:0]    value_ff, value_in;
   logic                rlast_ff, rlast_in;

   logic [DUR_W+TW-1:0] jm_q_ff;
   logic                ch_q_ff;

   logic                accept;
   logic                add_job;
   logic [XW-1:0]       dx;
   logic [TW-1:0]       d_clip;
   logic [CNTW-1:0]     i_m1;
   logic [JW-1:0]       tb_idx;
   logic                out_free;
   logic                tb_pick;
   logic [DUR_W-1:0]    tb_dur;
   logic [TW-1:0]       tb_dprev;
   logic [XW-1:0]       nj;
   logic [XW-1:0]       njc;

   logic                sub_en;
   logic [TW-1:0]       sub_j;
   logic [TW-1:0]       sub_dp;
   logic                ch_valid;
   logic [TW-1:0]       ch_j;
   logic                ch_pick;
   logic [ROW_W-1:0]    row_skip;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // deadlines beyond the row are clipped to the last finishing time
   assign dx     = XW'(req_job_deadline);
   assign d_clip = (dx > XW'(MAX_TIME)) ? TW'(MAX_TIME) : dx[TW-1:0];

   assign add_job = accept && (err_ff == KIND_NONE) && (count_ff < CNTW'(MAX_JOBS))
                    && !(d_clip < prevd_ff);

   assign i_m1   = i_ff - CNTW'(1);
   assign tb_idx = i_m1[JW-1:0];

   assign {tb_dur, tb_dprev} = jm_q_ff;

   // row unit: sweeps during SWEEP, otherwise reads the total at the last deadline
   assign sub_en = (state_ff == S_SWEEP);
   assign sub_j  = sub_en ? j_ff : prevd_ff;
   assign sub_dp = sub_en ? dp_ff : prevd_ff;

   dps_row_unit #(
      .MAX_TIME (MAX_TIME)
   ) u_row (
      .clock    (clock),
      .reset    (reset),
      .sweep_en (sub_en),
      .sweep_j  (sub_j),
      .sweep_dp (sub_dp),
      .job_t    (t_ff),
      .job_p    (p_ff),
      .ch_valid (ch_valid),
      .ch_j     (ch_j),
      .ch_pick  (ch_pick),
      .row_skip (row_skip)
   );

   // traceback step: a choice bit at time zero never counts
   always_comb begin
      tb_pick = ch_q_ff && (jt_ff != '0);
      nj      = XW'(jt_ff);
      if (tb_pick) begin
         nj = (XW'(jt_ff) >= XW'(tb_dur)) ? XW'(jt_ff) - XW'(tb_dur) : '0;
      end
      njc = (nj < XW'(tb_dprev)) ? nj : XW'(tb_dprev);
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      err_in       = err_ff;
      prevd_in     = prevd_ff;
      last_in      = last_ff;
      j_in         = j_ff;
      dp_in        = dp_ff;
      idx_in       = idx_ff;
      t_in         = t_ff;
      p_in         = p_ff;
      i_in         = i_ff;
      jt_in        = jt_ff;
      mask_in      = mask_ff;
      k_in         = k_ff;
      total_in     = total_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      kind_in      = kind_ff;
      value_in     = value_ff;
      rlast_in     = rlast_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               last_in  = req_last_job;
               state_in = S_DRAIN;
               if (add_job) begin
                  idx_in   = count_ff[JW-1:0];
                  dp_in    = prevd_ff;
                  j_in     = d_clip;
                  t_in     = req_job_duration;
                  p_in     = req_job_profit;
                  count_in = count_ff + CNTW'(1);
                  prevd_in = d_clip;
                  if (d_clip != '0) begin
                     state_in = S_SWEEP;
                  end
               end else if (err_ff == KIND_NONE) begin
                  // first error wins
                  err_in = (count_ff >= CNTW'(MAX_JOBS)) ? KIND_COUNT : KIND_ORDER;
               end
            end
         end
         S_SWEEP: begin
            j_in = j_ff - TW'(1);
            if (j_ff == TW'(1)) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (!last_ff) begin
               state_in = S_IDLE;
            end else if (err_ff != KIND_NONE) begin
               state_in = S_EMIT_ERR;
            end else begin
               state_in = S_TOT_RD;
            end
         end
         S_TOT_RD: begin
            state_in = S_TOT_WAIT;
         end
         S_TOT_WAIT: begin
            total_in = row_skip;
            i_in     = count_ff;
            jt_in    = prevd_ff;
            mask_in  = '0;
            state_in = S_TB_RD;
         end
         S_TB_RD: begin
            state_in = (i_ff == '0) ? S_EMIT_TOT : S_TB_USE;
         end
         S_TB_USE: begin
            if (tb_pick) begin
               mask_in[tb_idx] = 1'b1;
            end
            jt_in    = njc[TW-1:0];
            i_in     = i_m1;
            state_in = S_TB_RD;
         end
         S_EMIT_TOT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               kind_in      = KIND_PROFIT;
               value_in     = VAL_W'(total_ff);
               rlast_in     = (mask_ff == '0);
               k_in         = '0;
               state_in     = S_EMIT_JOB;
               if (mask_ff == '0) begin
                  count_in = '0;
                  err_in   = KIND_NONE;
                  prevd_in = '0;
                  state_in = S_IDLE;
               end
            end
         end
         S_EMIT_JOB: begin
            if (!mask_ff[k_ff]) begin
               k_in = k_ff + JW'(1);
            end else if (out_free) begin
               mask_in[k_ff] = 1'b0;
               rsp_valid_in  = 1'b1;
               kind_in       = KIND_JOB;
               value_in      = VAL_W'(k_ff) + VAL_W'(1);
               rlast_in      = (mask_in == '0);
               k_in          = k_ff + JW'(1);
               if (mask_in == '0) begin
                  count_in = '0;
                  err_in   = KIND_NONE;
                  prevd_in = '0;
                  state_in = S_IDLE;
               end
            end
         end
         S_EMIT_ERR: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               kind_in      = err_ff;
               value_in     = '0;
               rlast_in     = 1'b1;
               count_in     = '0;
               err_in       = KIND_NONE;
               prevd_in     = '0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         err_ff       <= KIND_NONE;
         prevd_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         err_ff       <= err_in;
         prevd_ff     <= prevd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff  <= last_in;
      j_ff     <= j_in;
      dp_ff    <= dp_in;
      idx_ff   <= idx_in;
      t_ff     <= t_in;
      p_ff     <= p_in;
      i_ff     <= i_in;
      jt_ff    <= jt_in;
      mask_ff  <= mask_in;
      k_ff     <= k_in;
      total_ff <= total_in;
      kind_ff  <= kind_in;
      value_ff <= value_in;
      rlast_ff <= rlast_in;
   end

   // job memory: written on an added job, read by the traceback
   always_ff @(posedge clock) begin
      if (add_job) begin
         job_mem[count_ff[JW-1:0]] <= {req_job_duration, prevd_ff};
      end
      jm_q_ff <= job_mem[tb_idx];
   end

   // choice bits, addressed by {job, finishing time}
   always_ff @(posedge clock) begin
      if (ch_valid) begin
         ch_mem[{idx_ff, ch_j}] <= ch_pick;
      end
      ch_q_ff <= ch_mem[{tb_idx, jt_ff}];
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_kind  = kind_ff;
   assign rsp_result_value = value_ff;
   assign rsp_result_last  = rlast_ff;

`ifndef SYNTHESIS
   a_tb_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_TB_USE) |-> ($past(state_ff) == S_TB_RD && i_ff != '0))
      else $error("traceback step without a fresh read");
   a_job_number: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_result_kind == KIND_JOB)
         |-> (rsp_result_value != '0 && rsp_result_value <= VAL_W'(MAX_JOBS)))
      else $error("chosen job number out of range");
   a_no_sweep_on_error: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SWEEP) |-> (err_ff == KIND_NONE && count_ff != '0))
      else $error("row sweep with a pending error");
   a_err_single: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_result_kind == KIND_ORDER || rsp_result_kind == KIND_COUNT))
         |-> (rsp_result_last && rsp_result_value == '0))
      else $error("error response not a lone final one");
`endif

endmodule
